FILE: rtl/barometric_pressure_compensation_core_assert.svh
// assertion macros for the pressure compensation core
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BPC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define BPC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/bpc_pkg.sv
// shared types, constants and helpers for the pressure compensation core
package bpc_pkg;
    localparam int unsigned DivBits  = 32;
    localparam int unsigned CfgIdxW  = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OSS    = 3'd0,
        REG_AC1AC2 = 3'd1,
        REG_AC3AC4 = 3'd2,
        REG_AC5AC6 = 3'd3,
        REG_B1B2   = 3'd4,
        REG_MCMD   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_press;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pressure_pa;
        logic               div_fault;
    } t_out_word;

    localparam logic [31:0] C4000  = 32'd4000;
    localparam logic [31:0] C3038  = 32'd3038;
    localparam logic [31:0] CM7357 = 32'hFFFF_E343;
    localparam logic [31:0] C3791  = 32'd3791;
    localparam logic [31:0] C50000 = 32'd50000;
    localparam logic [31:0] C32768 = 32'd32768;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    // one restoring step: remainder and quotient shift by one bit
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st st, input logic [31:0] d);
        t_div_st  o;
        logic [32:0] t;
        t = {st.rem, st.quo[31]} - {1'b0, d};
        o.quo = {st.quo[30:0], ~t[32]};
        o.rem = t[32] ? {st.rem[30:0], st.quo[31]} : t[31:0];
        return o;
    endfunction
endpackage

FILE: rtl/bpc_udiv.sv
// pipelined 32-bit unsigned divider, one quotient bit per stage, with side data
module bpc_udiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [31:0]                i_num,
    input  logic [31:0]                i_den,
    input  logic [127:0]               i_side,
    output logic                       o_valid,
    output logic [31:0]                o_quo,
    output logic [127:0]               o_side
);
    localparam int unsigned N = bpc_pkg::DivBits;

    logic                 r_v   [N];
    bpc_pkg::t_div_st     r_st  [N];
    logic [31:0]          r_d   [N];
    logic [127:0]         r_sd  [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= bpc_pkg::div_step('{rem: 32'd0, quo: i_num}, i_den);
            r_d[0]  <= i_den;
            r_sd[0] <= i_side;
            for (int k = 1; k < N; k++) begin
                r_st[k] <= bpc_pkg::div_step(r_st[k-1], r_d[k-1]);
                r_d[k]  <= r_d[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_st[N-1].quo;
    assign o_side  = r_sd[N-1];
endmodule

FILE: rtl/barometric_pressure_compensation_core.sv
// pressure compensation core: top level with the compensation pipeline
// Usage
//   Input channel: i_in_valid / o_in_stall carry one word of raw temperature
//   and raw pressure. Output channel: o_out_valid / i_out_stall carry one
//   word of compensated pressure and a divide fault flag.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write oss and the packed
//   calibration coefficients; write them only while the pipeline is empty.
//   Throughput: one word per cycle, sustained, when the output is not stalled.
//   Pipeline: two 32-stage dividers (temperature term and pressure
//   quotient) plus eleven registered stages around them.
//   Each word moves through registered stages with its own valid bit.
//   A stall at the output freezes the whole pipeline; o_in_stall follows
//   i_out_stall only when the final stage holds a word, so bubbles drain.
//   Nothing is lost or repeated under stall.
//   Reset (i_rst_n low, synchronous) clears all valid bits and all
//   configuration registers to zero.
//   A zero divisor yields pressure 0 with the fault flag set.
module barometric_pressure_compensation_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bpc_pkg::t_in_word     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bpc_pkg::t_out_word    o_out_data,
    input  logic                  i_cfg_we,
    input  logic [bpc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    `include "barometric_pressure_compensation_core_assert.svh"

    logic [1:0]  r_oss;
    logic [31:0] r_c1, r_c2, r_c3, r_c4, r_c5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0; r_c5 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::REG_OSS:    r_oss <= i_cfg_data[1:0];
                bpc_pkg::REG_AC1AC2: r_c1  <= i_cfg_data;
                bpc_pkg::REG_AC3AC4: r_c2  <= i_cfg_data;
                bpc_pkg::REG_AC5AC6: r_c3  <= i_cfg_data;
                bpc_pkg::REG_B1B2:   r_c4  <= i_cfg_data;
                bpc_pkg::REG_MCMD:   r_c5  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bpc_pkg::sx16(r_c1[31:16]);
    assign ac2 = bpc_pkg::sx16(r_c1[15:0]);
    assign ac3 = bpc_pkg::sx16(r_c2[31:16]);
    assign ac4 = {16'd0, r_c2[15:0]};
    assign ac5 = {16'd0, r_c3[31:16]};
    assign ac6 = {16'd0, r_c3[15:0]};
    assign b1  = bpc_pkg::sx16(r_c4[31:16]);
    assign b2  = bpc_pkg::sx16(r_c4[15:0]);
    assign mc  = bpc_pkg::sx16(r_c5[31:16]);
    assign md  = bpc_pkg::sx16(r_c5[15:0]);

    // global enable: the pipeline advances unless a finished word is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // stage 1: ut - ac6 times ac5
    logic        r1_v; logic [31:0] r1_x; logic [18:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x  <= bpc_pkg::mul32({16'd0, i_in_data.raw_temp} - ac6, ac5);
            r1_up <= i_in_data.raw_press;
        end
    end

    // stage 2: x1 and the temperature divider operands, made sign-magnitude
    logic        r2_v; logic [31:0] r2_x1, r2_ma, r2_mb; logic r2_neg, r2_f;
    logic [18:0] r2_up;
    logic [31:0] s2_x1, s2_den, s2_num;
    always_comb begin
        s2_x1  = bpc_pkg::asr(r1_x, 5'd15);
        s2_den = s2_x1 + md;
        s2_num = mc << 11;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1  <= s2_x1;
            r2_ma  <= s2_num[31] ? 32'd0 - s2_num : s2_num;
            r2_mb  <= s2_den[31] ? 32'd0 - s2_den : s2_den;
            r2_neg <= s2_num[31] ^ s2_den[31];
            r2_f   <= (s2_den == 32'd0);
            r2_up  <= r1_up;
        end
    end

    // temperature divider
    logic         d1_v; logic [31:0] d1_q; logic [127:0] d1_sd;
    bpc_udiv u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_v),
        .i_num(r2_ma), .i_den(r2_mb),
        .i_side({r2_x1, 13'd0, r2_up, r2_neg, r2_f, 62'd0}),
        .o_valid(d1_v), .o_quo(d1_q), .o_side(d1_sd)
    );
    logic [31:0] d1_x1; logic [18:0] d1_up; logic d1_neg, d1_f;
    assign d1_x1  = d1_sd[127:96];
    assign d1_up  = d1_sd[82:64];
    assign d1_neg = d1_sd[63];
    assign d1_f   = d1_sd[62];

    // stage 3: b6
    logic r3_v, r3_f; logic [31:0] r3_b6; logic [18:0] r3_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b6 <= d1_x1 + (d1_neg ? 32'd0 - d1_q : d1_q) - bpc_pkg::C4000;
            r3_f  <= d1_f;
            r3_up <= d1_up;
        end
    end

    // stage 4: b6 squared, ac2*b6, ac3*b6
    logic r4_v, r4_f; logic [31:0] r4_sq, r4_p2, r4_p3; logic [18:0] r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sq <= bpc_pkg::mul32(r3_b6, r3_b6);
            r4_p2 <= bpc_pkg::mul32(ac2, r3_b6);
            r4_p3 <= bpc_pkg::mul32(ac3, r3_b6);
            r4_f  <= r3_f;
            r4_up <= r3_up;
        end
    end

    // stage 5: b2*sq and b1*sq
    logic r5_v, r5_f; logic [31:0] r5_q2, r5_q1, r5_p2, r5_p3; logic [18:0] r5_up;
    logic [31:0] s4_sq;
    assign s4_sq = bpc_pkg::asr(r4_sq, 5'd12);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_q2 <= bpc_pkg::mul32(b2, s4_sq);
            r5_q1 <= bpc_pkg::mul32(b1, s4_sq);
            r5_p2 <= r4_p2;
            r5_p3 <= r4_p3;
            r5_f  <= r4_f;
            r5_up <= r4_up;
        end
    end

    // stage 6: b3 and the b4 factor
    logic r6_v, r6_f; logic [31:0] r6_b3, r6_x3; logic [18:0] r6_up;
    logic [31:0] s5_x3a, s5_t, s5_b3, s5_x3b;
    always_comb begin
        s5_x3a = bpc_pkg::asr(r5_q2, 5'd11) + bpc_pkg::asr(r5_p2, 5'd11);
        s5_t   = ((((ac1 << 2) + s5_x3a) << r_oss) + 32'd2);
        // signed divide by four truncating toward zero
        s5_b3  = s5_t[31] ? 32'd0 - ((32'd0 - s5_t) >> 2) : s5_t >> 2;
        s5_x3b = bpc_pkg::asr(bpc_pkg::asr(r5_p3, 5'd13)
                 + bpc_pkg::asr(r5_q1, 5'd16) + 32'd2, 5'd2);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_b3 <= s5_b3;
            r6_x3 <= s5_x3b + bpc_pkg::C32768;
            r6_f  <= r5_f;
            r6_up <= r5_up;
        end
    end

    // stage 7: b4 and b7 products
    logic r7_v, r7_f; logic [31:0] r7_b4p, r7_b7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_b4p <= bpc_pkg::mul32(ac4, r6_x3);
            r7_b7  <= bpc_pkg::mul32({13'd0, r6_up} - r6_b3, bpc_pkg::C50000 >> r_oss);
            r7_f   <= r6_f;
        end
    end

    // stage 8: divider operands
    logic r8_v, r8_f, r8_big; logic [31:0] r8_num, r8_b4;
    logic [31:0] s7_b4;
    assign s7_b4 = r7_b4p >> 15;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_big <= r7_b7[31];
            r8_num <= r7_b7[31] ? r7_b7 : r7_b7 << 1;
            r8_b4  <= s7_b4;
            r8_f   <= r7_f || (s7_b4 == 32'd0);
        end
    end

    logic d2_v; logic [31:0] d2_q; logic [127:0] d2_sd;
    bpc_udiv u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_num), .i_den(r8_b4), .i_side({r8_big, r8_f, 126'd0}),
        .o_valid(d2_v), .o_quo(d2_q), .o_side(d2_sd)
    );

    // stage 9: p and square of p>>8, -7357*p
    logic r9_v, r9_f; logic [31:0] r9_p, r9_sq, r9_m;
    logic [31:0] s9_p;
    assign s9_p = d2_sd[127] ? d2_q << 1 : d2_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en) r9_v <= d2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_p  <= s9_p;
            r9_sq <= bpc_pkg::mul32(bpc_pkg::asr(s9_p, 5'd8), bpc_pkg::asr(s9_p, 5'd8));
            r9_m  <= bpc_pkg::mul32(bpc_pkg::CM7357, s9_p);
            r9_f  <= d2_sd[126];
        end
    end

    // stage 10: times 3038
    logic r10_v, r10_f; logic [31:0] r10_p, r10_a, r10_m;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en) r10_v <= r9_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_a <= bpc_pkg::mul32(r9_sq, bpc_pkg::C3038);
            r10_p <= r9_p;
            r10_m <= r9_m;
            r10_f <= r9_f;
        end
    end

    // output register
    logic r_ov; bpc_pkg::t_out_word r_od;
    logic [31:0] s10_p;
    assign s10_p = r10_p + bpc_pkg::asr(bpc_pkg::asr(r10_a, 5'd16)
                   + bpc_pkg::asr(r10_m, 5'd16) + bpc_pkg::C3791, 5'd4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r10_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od.pressure_pa <= r10_f ? 32'sd0 : $signed(s10_p);
            r_od.div_fault   <= r10_f;
        end
    end
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    `BPC_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "input not stalled while output held")
    `BPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "held word changed")
    `BPC_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, o_out_valid && o_out_data.div_fault, o_out_data.pressure_pa == 32'sd0, "fault word with nonzero pressure")
    `BPC_ASSERT_IMP(a_free_run, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "stall without a held word")
endmodule
